/* rtl/idtt_pkg.sv */
// ---------------------------------------------------------------------------
// idtt_pkg: shared definitions for the interrupt domain translation table
// Field widths, opcodes, status codes and the compare flag bundle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package idtt_pkg;

  localparam int DEF_MAX_DOMAINS = 16;
  localparam int DEF_MAX_VIRQS   = 1024;

  localparam int OP_W   = 2;
  localparam int CHIP_W = 8;
  localparam int NODE_W = 32;
  localparam int HW_W   = 32;
  localparam int VBIN_W = 11;
  localparam int CNT_W  = 11;
  localparam int ST_W   = 3;
  localparam int VIRQ_W = 10;

  localparam logic [OP_W-1:0] OP_ADD      = 2'd0;
  localparam logic [OP_W-1:0] OP_MAP_CHIP = 2'd1;
  localparam logic [OP_W-1:0] OP_MAP_NODE = 2'd2;
  localparam logic [OP_W-1:0] OP_BIND     = 2'd3;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_INVALID  = 3'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [ST_W-1:0] ST_EXISTS   = 3'd4;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd5;

  typedef struct packed {
    logic overlap;    // virtual ranges intersect
    logic identical;  // all five fields equal
    logic same_hw;    // chip, hw base and size equal
    logic chip_eq;
    logic node_eq;
    logic node_zero;  // entry holds no node
    logic hw_hit;     // hw number inside entry hw range
  } match_flags_t;

endpackage
`default_nettype wire

/* rtl/idtt_entry_ram.sv */
// ---------------------------------------------------------------------------
// idtt_entry_ram: domain entry store
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module idtt_entry_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int W     = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/idtt_match.sv */
// ---------------------------------------------------------------------------
// idtt_match: shared entry compare unit
// Compares one stored entry against the request held by the sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module idtt_match #(
  parameter int VW = 10,
  parameter int CW = 12
) (
  input  wire logic [idtt_pkg::CHIP_W-1:0] e_chip,
  input  wire logic [idtt_pkg::NODE_W-1:0] e_node,
  input  wire logic [idtt_pkg::HW_W-1:0]   e_hw,
  input  wire logic [VW-1:0]               e_vb,
  input  wire logic [idtt_pkg::CNT_W-1:0]  e_size,
  input  wire logic [idtt_pkg::CHIP_W-1:0] q_chip,
  input  wire logic [idtt_pkg::NODE_W-1:0] q_node,
  input  wire logic [idtt_pkg::HW_W-1:0]   q_hw,
  input  wire logic [CW-1:0]               q_base,
  input  wire logic [idtt_pkg::CNT_W-1:0]  q_size,
  output idtt_pkg::match_flags_t           flags,
  output logic [CW-1:0]                    e_end,
  output logic [idtt_pkg::VIRQ_W-1:0]      e_virq,
  output logic [idtt_pkg::VIRQ_W-1:0]      map_virq
);
  import idtt_pkg::*;

  logic [CW-1:0]   vb_ext;
  logic [CW-1:0]   q_end;
  logic [HW_W:0]   hw_end;
  logic [HW_W-1:0] hw_diff;
  logic [CW-1:0]   map_sum;

  assign vb_ext  = CW'(e_vb);
  assign e_end   = vb_ext + CW'(e_size);
  assign q_end   = q_base + CW'(q_size);
  assign hw_end  = {1'b0, e_hw} + (HW_W + 1)'(e_size);
  assign hw_diff = q_hw - e_hw;
  // offset is below the entry size whenever it is used
  assign map_sum = vb_ext + CW'(hw_diff[CNT_W-1:0]);

  assign e_virq   = vb_ext[VIRQ_W-1:0];
  assign map_virq = map_sum[VIRQ_W-1:0];

  always_comb begin
    flags.overlap   = (vb_ext < q_end) && (q_base < e_end);
    flags.chip_eq   = (e_chip == q_chip);
    flags.node_eq   = (e_node == q_node);
    flags.node_zero = (e_node == '0);
    flags.same_hw   = flags.chip_eq && (e_hw == q_hw) && (e_size == q_size);
    flags.identical = flags.same_hw && flags.node_eq && (vb_ext == q_base);
    flags.hw_hit    = (q_hw >= e_hw) && ({1'b0, q_hw} < hw_end);
  end

endmodule
`default_nettype wire

/* rtl/irq_domain_translation_table.sv */
// ---------------------------------------------------------------------------
// irq_domain_translation_table: linear interrupt domain remap table
// Adds domains, translates hardware numbers and binds firmware nodes.
// ---------------------------------------------------------------------------
// Usage: raise start with the request fields while busy is low; the
// transaction is taken at that edge; if valid, busy rises the next cycle. The
// block works on one request at a time. Every request gives one result:
// out_valid is high for exactly one cycle with out_status and out_virq,
// and the receiver must take it then, it cannot stall the block.
// Operation: the entries live in a memory with one read port, and a shared
// compare unit checks one entry per cycle. A request rejected on its
// fields has its result registered at the accepting edge itself. Map
// scans the live domains once, bind makes two passes over them, and add
// with a given base checks the range, then scans once. Add with automatic
// base runs a first-fit search that restarts the scan after every
// collision, each entry colliding at most once.
// A new request may be started in the cycle of the result strobe.
// Reset empties the table (domain count to zero); the entry memory is not
// cleared, as entries at or beyond the count are never used.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module irq_domain_translation_table #(
  parameter int MAX_DOMAINS = idtt_pkg::DEF_MAX_DOMAINS,
  parameter int MAX_VIRQS   = idtt_pkg::DEF_MAX_VIRQS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [idtt_pkg::OP_W-1:0]   in_opcode,
  input  wire logic [idtt_pkg::CHIP_W-1:0] in_chip_id,
  input  wire logic [idtt_pkg::NODE_W-1:0] in_fwnode,
  input  wire logic [idtt_pkg::HW_W-1:0]   in_hw_number,
  input  wire logic [idtt_pkg::VBIN_W-1:0] in_vbase,
  input  wire logic                        in_auto_virq,
  input  wire logic [idtt_pkg::CNT_W-1:0]  in_count,
  output logic                             out_valid,
  output logic [idtt_pkg::ST_W-1:0]        out_status,
  output logic [idtt_pkg::VIRQ_W-1:0]      out_virq
);
  import idtt_pkg::*;

  localparam int KW = $clog2(MAX_DOMAINS + 1);
  localparam int AW = (MAX_DOMAINS > 1) ? $clog2(MAX_DOMAINS) : 1;
  localparam int VW = (MAX_VIRQS > 1) ? $clog2(MAX_VIRQS) : 1;
  localparam int CW = ((VW > CNT_W) ? VW : CNT_W) + 1;
  localparam int EW = CHIP_W + NODE_W + HW_W + VW + CNT_W;
  localparam logic [CW-1:0] MAXV = CW'(MAX_VIRQS);
  localparam logic [KW-1:0] MAXD = KW'(MAX_DOMAINS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FIT   = 5'b00010,
    S_CHECK = 5'b00100,
    S_SCAN  = 5'b01000,
    S_SCAN2 = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [CHIP_W-1:0] chip_r, chip_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [HW_W-1:0]   hw_r, hw_nxt;
  logic [CW-1:0]     base_r, base_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [KW-1:0]     count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [VIRQ_W-1:0] out_virq_r, out_virq_nxt;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [EW-1:0]     wdata;
  logic [EW-1:0]     rdata;

  logic [CHIP_W-1:0] e_chip;
  logic [NODE_W-1:0] e_node;
  logic [HW_W-1:0]   e_hw;
  logic [VW-1:0]     e_vb;
  logic [CNT_W-1:0]  e_size;
  match_flags_t      flags;
  logic [CW-1:0]     e_end;
  logic [VIRQ_W-1:0] e_virq;
  logic [VIRQ_W-1:0] map_virq;

  logic              at_end;
  logic [CW-1:0]     limit;
  logic              fin;
  logic [ST_W-1:0]   fin_st;
  logic [VIRQ_W-1:0] fin_virq;

  assign {e_chip, e_node, e_hw, e_vb, e_size} = rdata;

  idtt_entry_ram #(
    .DEPTH (MAX_DOMAINS),
    .AW    (AW),
    .W     (EW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (k_nxt[AW-1:0]),
    .rdata (rdata)
  );

  idtt_match #(
    .VW (VW),
    .CW (CW)
  ) u_match (
    .e_chip   (e_chip),
    .e_node   (e_node),
    .e_hw     (e_hw),
    .e_vb     (e_vb),
    .e_size   (e_size),
    .q_chip   (chip_r),
    .q_node   (node_r),
    .q_hw     (hw_r),
    .q_base   (base_r),
    .q_size   (n_r),
    .flags    (flags),
    .e_end    (e_end),
    .e_virq   (e_virq),
    .map_virq (map_virq)
  );

  assign at_end = (k_r == count_r);
  assign limit  = MAXV - CW'(n_r);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    chip_nxt  = chip_r;
    node_nxt  = node_r;
    hw_nxt    = hw_r;
    base_nxt  = base_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    count_nxt = count_r;
    fin       = 1'b0;
    fin_st    = ST_OK;
    fin_virq  = '0;
    we        = 1'b0;
    waddr     = k_r[AW-1:0];
    wdata     = {e_chip, node_r, e_hw, e_vb, e_size};

    case (state_r)
      S_IDLE: begin
        k_nxt = '0;
        if (start) begin
          op_nxt   = in_opcode;
          chip_nxt = in_chip_id;
          node_nxt = in_fwnode;
          hw_nxt   = in_hw_number;
          n_nxt    = in_count;
          base_nxt = CW'(in_vbase);
          case (in_opcode)
            OP_ADD: begin
              if (in_chip_id == '0 || in_count == '0) begin
                fin    = 1'b1;
                fin_st = ST_INVALID;
              end else if (in_auto_virq) begin
                if (CW'(in_count) > MAXV) begin
                  fin    = 1'b1;
                  fin_st = ST_INVALID;
                end else begin
                  base_nxt  = '0;
                  state_nxt = S_FIT;
                end
              end else begin
                state_nxt = S_CHECK;
              end
            end
            OP_MAP_CHIP: begin
              if (in_chip_id == '0) begin
                fin    = 1'b1;
                fin_st = ST_INVALID;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_MAP_NODE: begin
              if (in_fwnode == '0) begin
                fin    = 1'b1;
                fin_st = ST_INVALID;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              if (in_chip_id == '0 || in_count == '0 || in_fwnode == '0) begin
                fin    = 1'b1;
                fin_st = ST_INVALID;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      S_FIT: begin
        // candidate is tested against the limit at the start of each scan
        if (k_r == '0 && base_r > limit) begin
          fin    = 1'b1;
          fin_st = ST_NOSPACE;
        end else if (at_end) begin
          k_nxt     = '0;
          state_nxt = S_CHECK;
        end else if (flags.overlap) begin
          base_nxt = (e_end > base_r) ? e_end : base_r + CW'(1);
          k_nxt    = '0;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end

      S_CHECK: begin
        k_nxt = '0;
        if (base_r >= MAXV || (base_r + CW'(n_r)) > MAXV) begin
          fin    = 1'b1;
          fin_st = ST_RANGE;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        k_nxt = k_r + KW'(1);
        case (op_r)
          OP_ADD: begin
            if (at_end) begin
              fin = 1'b1;
              if (count_r >= MAXD) begin
                fin_st = ST_NOSPACE;
              end else begin
                we        = 1'b1;
                waddr     = count_r[AW-1:0];
                wdata     = {chip_r, node_r, hw_r, base_r[VW-1:0], n_r};
                count_nxt = count_r + KW'(1);
                fin_virq  = base_r[VIRQ_W-1:0];
              end
            end else if (flags.identical) begin
              fin      = 1'b1;
              fin_virq = e_virq;
            end else if (flags.overlap || (node_r != '0 && flags.node_eq)) begin
              fin    = 1'b1;
              fin_st = ST_EXISTS;
            end
          end
          OP_MAP_CHIP, OP_MAP_NODE: begin
            if (at_end) begin
              fin    = 1'b1;
              fin_st = ST_NOTFOUND;
            end else if (flags.hw_hit && ((op_r == OP_MAP_CHIP) ? flags.chip_eq
                         : (flags.node_eq && !flags.node_zero))) begin
              fin      = 1'b1;
              fin_virq = map_virq;
            end
          end
          default: begin
            // bind, first pass: node held by a different domain
            if (at_end) begin
              k_nxt     = '0;
              state_nxt = S_SCAN2;
            end else if (flags.node_eq && !flags.same_hw) begin
              fin    = 1'b1;
              fin_st = ST_EXISTS;
            end
          end
        endcase
      end

      S_SCAN2: begin
        k_nxt = k_r + KW'(1);
        if (at_end) begin
          fin    = 1'b1;
          fin_st = ST_NOTFOUND;
        end else if (flags.same_hw) begin
          fin = 1'b1;
          if (flags.node_zero || flags.node_eq) begin
            we = 1'b1;
          end else begin
            fin_st = ST_EXISTS;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
      k_nxt     = '0;
    end
    out_valid_nxt  = fin;
    out_status_nxt = fin_st;
    out_virq_nxt   = (fin_st == ST_OK) ? fin_virq : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    chip_r       <= chip_nxt;
    node_r       <= node_nxt;
    hw_r         <= hw_nxt;
    base_r       <= base_nxt;
    n_r          <= n_nxt;
    out_status_r <= out_status_nxt;
    out_virq_r   <= out_virq_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_virq   = out_virq_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAXD) else $error("domain count beyond table depth");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_virq == '0)
    else $error("nonzero virq on error status");

  a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction neither started nor answered");
`endif

endmodule
`default_nettype wire
